// ----- src/mkrq_pkg.sv -----
// Shared types, constants and the usage lookup for the media key report queue.
// No dependencies; compiled first.
package mkrq_pkg;

  localparam int unsigned QueueDepthDefault = 16;
  localparam logic [15:0] ReleaseDelayReset = 16'd8;

  typedef enum logic [1:0] {
    OP_ENQUEUE = 2'd0,
    OP_TICK    = 2'd1,
    OP_SUSPEND = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    ACT_PLAY_PAUSE = 3'd0,
    ACT_NEXT       = 3'd1,
    ACT_PREVIOUS   = 3'd2,
    ACT_VOL_UP     = 3'd3,
    ACT_VOL_DOWN   = 3'd4,
    ACT_MUTE       = 3'd5
  } action_e;

  localparam logic [9:0] UsagePlayPause = 10'h0CD;
  localparam logic [9:0] UsageNext      = 10'h0B5;
  localparam logic [9:0] UsagePrevious  = 10'h0B6;
  localparam logic [9:0] UsageVolUp     = 10'h0E9;
  localparam logic [9:0] UsageVolDown   = 10'h0EA;
  localparam logic [9:0] UsageMute      = 10'h0E2;
  localparam logic [9:0] UsageRelease   = 10'h000;

  typedef struct packed {
    logic [1:0]  op;
    logic [2:0]  action;
    logic        reserved_ok;
    logic [31:0] now_ms;
    logic        bus_suspended;
    logic        endpoint_ready;
    logic        report_taken;
    logic        wake_permitted;
  } item_t;

  typedef struct packed {
    logic       enqueue_ok;
    logic       report_valid;
    logic [9:0] report_usage;
  } result_t;

  function automatic logic [9:0] usage_of(input logic [2:0] action);
    logic [9:0] usage;
    case (action)
      ACT_PLAY_PAUSE: usage = UsagePlayPause;
      ACT_NEXT:       usage = UsageNext;
      ACT_PREVIOUS:   usage = UsagePrevious;
      ACT_VOL_UP:     usage = UsageVolUp;
      ACT_VOL_DOWN:   usage = UsageVolDown;
      ACT_MUTE:       usage = UsageMute;
      default:        usage = UsageRelease;
    endcase
    return usage;
  endfunction

endpackage

// ----- src/mkrq_if.sv -----
// Valid/ready channel interfaces of the media key report queue.
// Depends on mkrq_pkg for the word types.
interface mkrq_item_if;
  import mkrq_pkg::*;
  logic  valid;
  logic  ready;
  item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface mkrq_result_if;
  import mkrq_pkg::*;
  logic    valid;
  logic    ready;
  result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface mkrq_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- src/media_key_report_queue.sv -----
// Media key report queue: ring queue of pending media actions plus press/release sequencing.
// Depends on mkrq_pkg and the channel interfaces in mkrq_if.sv.
//
// A word accepted on item_i gives exactly one word on result_o. It passes through
// the input register, during which the head slot of the action store is already
// read from its registered port, and then the result register. One word is taken
// every cycle as long as result_o is drained.
// The input register and the result register each hold a word, so one more word
// is taken while a finished result waits, after which item_i stalls until result_o
// is read. The action store is a QUEUE_DEPTH-entry memory with one write and one
// registered read port and needs no clearing after reset. Configuration words on
// cfg_i are always accepted and take effect from the next cycle; write them only
// while the block is idle.
module media_key_report_queue #(
  parameter int unsigned QUEUE_DEPTH = mkrq_pkg::QueueDepthDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  mkrq_item_if.sink          item_i,
  mkrq_result_if.source      result_o,
  mkrq_cfg_if.sink           cfg_i
);
  import mkrq_pkg::*;

  localparam int unsigned SlotW = $clog2(QUEUE_DEPTH);
  localparam logic [SlotW-1:0] LastSlot = SlotW'(QUEUE_DEPTH - 1);

  function automatic logic [SlotW-1:0] next_slot(input logic [SlotW-1:0] s);
    return (s == LastSlot) ? '0 : s + 1'b1;
  endfunction

  item_t            item_q;
  logic             item_valid_q;
  result_t          result_q, result_d;
  logic             result_valid_q;
  logic [SlotW-1:0] rd_q, rd_d;
  logic [SlotW-1:0] wr_q, wr_d;
  logic             key_down_q, key_down_d;
  logic [31:0]      deadline_q, deadline_d;
  logic             wake_q, wake_d;
  logic [15:0]      delay_q;
  logic [2:0]       head_q;
  logic [2:0]       store [QUEUE_DEPTH];
  logic             adv;
  logic             we;

  assign adv          = item_valid_q && (!result_valid_q || result_o.ready);
  assign item_i.ready = !item_valid_q || adv;
  assign cfg_i.ready  = 1'b1;

  assign result_o.valid = result_valid_q;
  assign result_o.data  = result_q;

  always_comb begin
    logic [SlotW-1:0] wr_next;
    logic [SlotW-1:0] rd_t;
    logic [SlotW-1:0] wr_t;
    logic             full;
    logic             last_only;
    logic [31:0]      diff;

    rd_d       = rd_q;
    wr_d       = wr_q;
    key_down_d = key_down_q;
    deadline_d = deadline_q;
    wake_d     = wake_q;
    result_d   = '0;
    we         = 1'b0;
    wr_next    = next_slot(wr_q);
    full       = (wr_next == rd_q);
    last_only  = (next_slot(wr_next) == rd_q);
    rd_t       = rd_q;
    wr_t       = wr_q;
    diff       = item_q.now_ms - deadline_q;

    if (adv) begin
      case (item_q.op)
        OP_ENQUEUE: begin
          // keep one slot empty; the last usable slot needs reserved_ok
          if (!full && !(last_only && !item_q.reserved_ok)) begin
            we                  = 1'b1;
            wr_d                = wr_next;
            result_d.enqueue_ok = 1'b1;
          end
        end
        OP_TICK: begin
          // flush on a suspended bus without wake permission
          if (item_q.bus_suspended && !wake_q) begin
            rd_t = '0;
            wr_t = '0;
          end
          rd_d = rd_t;
          wr_d = wr_t;
          if (key_down_q) begin
            if (!diff[31] && item_q.endpoint_ready) begin
              result_d.report_valid = 1'b1;
              result_d.report_usage = UsageRelease;
              if (item_q.report_taken) begin
                key_down_d = 1'b0;
              end
            end
          end else if (rd_t != wr_t && item_q.endpoint_ready) begin
            result_d.report_valid = 1'b1;
            result_d.report_usage = usage_of(head_q);
            if (item_q.report_taken) begin
              rd_d       = next_slot(rd_t);
              key_down_d = 1'b1;
              deadline_d = item_q.now_ms + {16'd0, delay_q};
            end
          end
        end
        OP_SUSPEND: begin
          wake_d = item_q.wake_permitted;
          rd_d   = '0;
          wr_d   = '0;
        end
        default: begin
        end
      endcase
    end
  end

  // action store; head_q always holds the word at the next head slot
  always_ff @(posedge clk_i) begin
    if (we) begin
      store[wr_q] <= item_q.action;
    end
    if (we && wr_q == rd_d) begin
      head_q <= item_q.action;
    end else begin
      head_q <= store[rd_d];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q   <= 1'b0;
      result_valid_q <= 1'b0;
      rd_q           <= '0;
      wr_q           <= '0;
      key_down_q     <= 1'b0;
      deadline_q     <= '0;
      wake_q         <= 1'b0;
      delay_q        <= ReleaseDelayReset;
    end else begin
      if (item_i.ready) begin
        item_valid_q <= item_i.valid;
      end
      if (adv) begin
        result_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        result_valid_q <= 1'b0;
      end
      rd_q       <= rd_d;
      wr_q       <= wr_d;
      key_down_q <= key_down_d;
      deadline_q <= deadline_d;
      wake_q     <= wake_d;
      if (cfg_i.valid) begin
        delay_q <= cfg_i.data;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_i.valid && item_i.ready) begin
      item_q <= item_i.data;
    end
    if (adv) begin
      result_q <= result_d;
    end
  end

endmodule

// ----- src/mkrq_checker.sv -----
// Port-level checks for media_key_report_queue, attached by the bind below.
// Depends on mkrq_pkg for the usage codes.
module mkrq_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       res_valid_i,
  input logic       res_ready_i,
  input logic       enqueue_ok_i,
  input logic       report_valid_i,
  input logic [9:0] report_usage_i
);
  import mkrq_pkg::*;

  // a word reports a stored enqueue, a report or neither, never both
  a_ok_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> !(enqueue_ok_i && report_valid_i))
    else $error("enqueue_ok and report_valid both set");

  a_usage_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_i && !report_valid_i) |-> (report_usage_i == UsageRelease))
    else $error("usage set without a report");

  a_usage_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> (report_usage_i == UsageRelease || report_usage_i == UsagePlayPause ||
                     report_usage_i == UsageNext || report_usage_i == UsagePrevious ||
                     report_usage_i == UsageVolUp || report_usage_i == UsageVolDown ||
                     report_usage_i == UsageMute))
    else $error("usage code outside the table");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_i && !res_ready_i) |=>
      (res_valid_i && $stable(enqueue_ok_i) && $stable(report_valid_i) &&
       $stable(report_usage_i)))
    else $error("stalled result word changed");

endmodule

bind media_key_report_queue mkrq_checker u_mkrq_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .res_valid_i    (result_o.valid),
  .res_ready_i    (result_o.ready),
  .enqueue_ok_i   (result_o.data.enqueue_ok),
  .report_valid_i (result_o.data.report_valid),
  .report_usage_i (result_o.data.report_usage)
);
